@@ src/swhc_pkg.sv @@
package swhc_pkg;

    // Field widths
    localparam int TS_W   = 31;
    localparam int HC_W   = 25;
    localparam int STAT_W = 2;
    localparam int WL_W   = 10;

    // Window length after reset
    localparam logic [WL_W-1:0] WL_RESET = 10'd300;

    // Command codes
    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_HIT   = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_DROPPED      = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OUT_OF_ORDER = 2'd2;

    // Item queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic            command;
        logic [TS_W-1:0] timestamp;
    } item_t;

    // Head of the item queue as seen by the back end
    typedef struct packed {
        logic            valid;
        logic            is_hit;
        logic [TS_W-1:0] timestamp;
    } head_t;

endpackage

@@ src/swhc_if.sv @@
interface swhc_item_if;
    import swhc_pkg::*;

    logic            valid;
    logic            ready;
    logic            command;
    logic [TS_W-1:0] timestamp;

    modport source (output valid, output command, output timestamp, input ready);
    modport sink   (input valid, input command, input timestamp, output ready);
endinterface

interface swhc_result_if;
    import swhc_pkg::*;

    logic              valid;
    logic              ready;
    logic [HC_W-1:0]   hit_count;
    logic [STAT_W-1:0] status;

    modport source (output valid, output hit_count, output status, input ready);
    modport sink   (input valid, input hit_count, input status, output ready);
endinterface

@@ src/sliding_window_hit_counter.sv @@
// Channel | Dir | Payload              | Handshake
// item    | in  | command, timestamp   | valid/ready
// result  | out | hit_count, status    | valid/ready
// cfg     | in  | cfg_wdata (window)   | cfg_we, no ready
//
// An item is loaded, evicts its expired buckets one by one, then finishes; the eviction walk is paced
// by the single read port of the bucket store, which follows the oldest bucket.
// Finishing one item and loading the next overlap, so steady traffic runs at one item per
// cycle while no bucket is evicted and the result sink is not stalled.
// Reset (rst_n low, asynchronous) empties the bucket FIFO and sets the window to 300 ticks.
// A two-beat item queue lets the input side keep taking beats while the result register
// waits on a stalled sink.
module sliding_window_hit_counter #(
    parameter int BUCKET_DEPTH = 512,
    parameter int COUNT_BITS   = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    swhc_item_if.sink                 item,
    swhc_result_if.source             result,
    input  logic                      cfg_we,
    input  logic [swhc_pkg::WL_W-1:0] cfg_wdata
);
    import swhc_pkg::*;

    head_t head;
    logic  pop;

    // Input queue and classification
    swhc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .pop   (pop),
        .head  (head)
    );

    // Bucket FIFO, eviction walk and result register
    swhc_back #(
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .COUNT_BITS   (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .pop       (pop),
        .result    (result)
    );

endmodule

@@ src/swhc_front.sv @@
module swhc_front (
    input  logic            clk,
    input  logic            rst_n,
    swhc_item_if.sink       item,
    input  logic            pop,
    output swhc_pkg::head_t head
);
    import swhc_pkg::*;

    item_t           q_mem [Q_DEPTH];
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;
    logic            push;
    item_t           q_head;

    function automatic logic [QP_W-1:0] ptr_inc(input logic [QP_W-1:0] p);
        return (p == QP_W'(Q_DEPTH - 1)) ? '0 : p + QP_W'(1);
    endfunction

    // Accept a beat whenever the queue has room
    assign item.ready = (count_reg < QC_W'(Q_DEPTH));
    assign push       = item.valid && item.ready;

    // Classify the head item for the back end
    assign q_head      = q_mem[rd_ptr_reg];
    assign head.valid  = (count_reg != '0);
    assign head.is_hit = (q_head.command == CMD_HIT);
    assign head.timestamp = q_head.timestamp;

    // Pointer and count update
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        end
        if (pop)
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QC_W'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{command: item.command, timestamp: item.timestamp};
        end
    end

endmodule

@@ src/swhc_back.sv @@
module swhc_back #(
    parameter int BUCKET_DEPTH = 512,
    parameter int COUNT_BITS   = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [swhc_pkg::WL_W-1:0] cfg_wdata,
    input  swhc_pkg::head_t           head,
    output logic                      pop,
    swhc_result_if.source             result
);
    import swhc_pkg::*;

    localparam int IDX_W  = $clog2(BUCKET_DEPTH);
    localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic {ST_IDLE, ST_WORK} state_t;

    state_t            state_reg, state_next;
    logic              cur_hit_reg, cur_hit_next;
    logic [TS_W-1:0]   cur_ts_reg, cur_ts_next;
    logic [IDX_W-1:0]  oldest_reg, oldest_next;
    logic [IDX_W-1:0]  newest_reg, newest_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [HC_W-1:0]   total_reg, total_next;
    logic [TS_W-1:0]   newest_time_reg, newest_time_next;
    logic [COUNT_BITS-1:0] newest_hits_reg, newest_hits_next;
    logic [WL_W-1:0]   wl_reg, wl_next;
    logic              out_valid_reg, out_valid_next;
    logic [HC_W-1:0]   out_count_reg, out_count_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;

    // Bucket store
    logic [TS_W-1:0]       mem_time [BUCKET_DEPTH];
    logic [COUNT_BITS-1:0] mem_hits [BUCKET_DEPTH];
    logic [TS_W-1:0]       rd_time_reg;
    logic [COUNT_BITS-1:0] rd_hits_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_hits;
    logic [IDX_W-1:0]      rd_addr;

    logic            out_free;
    logic            ooo;
    logic            same_bucket;
    logic            evict;
    logic            finish;
    logic [TS_W-1:0] age;
    logic [IDX_W-1:0] push_slot;

    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
        return (s == IDX_W'(BUCKET_DEPTH - 1)) ? '0 : s + IDX_W'(1);
    endfunction

    // Decisions on the item under work
    assign out_free    = !out_valid_reg || result.ready;
    assign ooo         = (fill_reg != '0) && (cur_ts_reg < newest_time_reg);
    assign age         = cur_ts_reg - rd_time_reg;
    assign evict       = (state_reg == ST_WORK) && !ooo && (fill_reg != '0)
                         && (age >= TS_W'(wl_reg));
    assign finish      = (state_reg == ST_WORK) && !evict && out_free;
    assign pop         = head.valid && ((state_reg == ST_IDLE) || finish);
    assign same_bucket = (fill_reg != '0) && (newest_time_reg == cur_ts_reg);
    assign push_slot   = (fill_reg == '0) ? oldest_reg : slot_inc(newest_reg);

    // Eviction walk, hit update and result
    always_comb
    begin
        state_next       = state_reg;
        cur_hit_next     = cur_hit_reg;
        cur_ts_next      = cur_ts_reg;
        oldest_next      = oldest_reg;
        newest_next      = newest_reg;
        fill_next        = fill_reg;
        total_next       = total_reg;
        newest_time_next = newest_time_reg;
        newest_hits_next = newest_hits_reg;
        wl_next          = cfg_we ? cfg_wdata : wl_reg;
        out_valid_next   = out_valid_reg;
        out_count_next   = out_count_reg;
        out_status_next  = out_status_reg;
        mem_we           = 1'b0;
        wr_addr          = newest_reg;
        wr_hits          = newest_hits_reg;

        // drop one expired bucket per cycle
        if (evict)
        begin
            total_next  = total_reg - HC_W'(rd_hits_reg);
            oldest_next = slot_inc(oldest_reg);
            fill_next   = fill_reg - FILL_W'(1);
        end

        if (finish)
        begin
            out_status_next = STATUS_OK;
            if (ooo)
            begin
                out_status_next = STATUS_OUT_OF_ORDER;
            end
            else if (cur_hit_reg)
            begin
                if (same_bucket)
                begin
                    if (newest_hits_reg == COUNT_MAX)
                    begin
                        out_status_next = STATUS_DROPPED;
                    end
                    else
                    begin
                        mem_we           = 1'b1;
                        wr_addr          = newest_reg;
                        wr_hits          = newest_hits_reg + COUNT_BITS'(1);
                        newest_hits_next = wr_hits;
                        total_next       = total_reg + HC_W'(1);
                    end
                end
                else if (fill_reg == FILL_W'(BUCKET_DEPTH))
                begin
                    out_status_next = STATUS_DROPPED;
                end
                else
                begin
                    mem_we           = 1'b1;
                    wr_addr          = push_slot;
                    wr_hits          = COUNT_BITS'(1);
                    newest_next      = push_slot;
                    newest_time_next = cur_ts_reg;
                    newest_hits_next = COUNT_BITS'(1);
                    fill_next        = fill_reg + FILL_W'(1);
                    total_next       = total_reg + HC_W'(1);
                end
            end
            out_valid_next = 1'b1;
            out_count_next = total_next;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        // load the next item, or go idle
        if (pop)
        begin
            state_next   = ST_WORK;
            cur_hit_next = head.is_hit;
            cur_ts_next  = head.timestamp;
        end
        else if (finish)
        begin
            state_next = ST_IDLE;
        end
    end

    // Read port follows the oldest bucket
    assign rd_addr = oldest_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            oldest_reg      <= '0;
            newest_reg      <= '0;
            fill_reg        <= '0;
            total_reg       <= '0;
            wl_reg          <= WL_RESET;
            out_valid_reg   <= 1'b0;
            cur_hit_reg     <= 1'b0;
            cur_ts_reg      <= '0;
            newest_time_reg <= '0;
            newest_hits_reg <= '0;
            out_count_reg   <= '0;
            out_status_reg  <= STATUS_OK;
        end
        else
        begin
            state_reg       <= state_next;
            oldest_reg      <= oldest_next;
            newest_reg      <= newest_next;
            fill_reg        <= fill_next;
            total_reg       <= total_next;
            wl_reg          <= wl_next;
            out_valid_reg   <= out_valid_next;
            cur_hit_reg     <= cur_hit_next;
            cur_ts_reg      <= cur_ts_next;
            newest_time_reg <= newest_time_next;
            newest_hits_reg <= newest_hits_next;
            out_count_reg   <= out_count_next;
            out_status_reg  <= out_status_next;
        end
    end

    // Bucket store, write-through on a same-address read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_time[wr_addr] <= cur_ts_reg;
            mem_hits[wr_addr] <= wr_hits;
        end
        if (mem_we && (wr_addr == rd_addr))
        begin
            rd_time_reg <= cur_ts_reg;
            rd_hits_reg <= wr_hits;
        end
        else
        begin
            rd_time_reg <= mem_time[rd_addr];
            rd_hits_reg <= mem_hits[rd_addr];
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.hit_count = out_count_reg;
    assign result.status    = out_status_reg;

    // Occupancy implied by the two slot pointers
    logic [IDX_W-1:0]  ptr_diff_fwd;
    logic [IDX_W-1:0]  ptr_diff_back;
    logic [FILL_W-1:0] span;

    assign ptr_diff_fwd  = newest_reg - oldest_reg;
    assign ptr_diff_back = oldest_reg - newest_reg;
    assign span = (newest_reg >= oldest_reg)
                  ? FILL_W'(ptr_diff_fwd) + FILL_W'(1)
                  : FILL_W'(BUCKET_DEPTH) - FILL_W'(ptr_diff_back) + FILL_W'(1);

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(BUCKET_DEPTH))
        else $error("bucket fill above depth");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (total_reg == '0))
        else $error("nonzero total with no live buckets");

    a_ptr_span: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != '0) |-> (span == fill_reg))
        else $error("slot pointers disagree with fill");

    a_ooo_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && ooo) |=> (fill_reg == $past(fill_reg))
                            && (total_reg == $past(total_reg)))
        else $error("out-of-order item changed the buckets");

endmodule
